FILE: rtl/rqs_pkg.sv
package rqs_pkg;

    // Default build values
    localparam int DEF_CAPACITY     = 1024;
    localparam int DEF_ELEMENT_BITS = 32;

    // Fixed field widths of the words
    localparam int ELEM_W   = 32;
    localparam int KIND_W   = 2;
    localparam int RAND_W   = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Input word
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ELEM_W-1:0] value;
        logic [RAND_W-1:0] random_word;
    } rqs_in_t;

    // Result word
    typedef struct packed {
        logic [ELEM_W-1:0]   element;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count_after;
        logic                is_empty;
    } rqs_out_t;

    // Controller to datapath
    typedef struct packed {
        logic                accept;       // latch the input word, read last slot
        logic                hold_last;    // capture last entry from the RAM
        logic                rd_pick;      // read the chosen slot
        logic                wr_add;       // append value, count up
        logic                wr_swap;      // move last entry into chosen slot, count down
        logic                emit;         // load the result register
        logic                take_element; // result carries the read entry
        logic [STATUS_W-1:0] status;
    } rqs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty;
        logic              full;
    } rqs_stat_t;

endpackage

FILE: rtl/rqs_ram.sv
module rqs_ram
    import rqs_pkg::*;
#(
    parameter int WIDTH = DEF_ELEMENT_BITS,
    parameter int DEPTH = DEF_CAPACITY
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rqs_ctrl.sv
module rqs_ctrl
    import rqs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  rqs_stat_t stat,
    output rqs_cmd_t  cmd,
    output logic      busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PICK = 3'b010,
        S_SWAP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                cmd.hold_last = 1'b1;
                priority if (stat.kind == KIND_ADD)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                    if (stat.full)
                    begin
                        cmd.status = ST_FULL;
                    end
                    else
                    begin
                        cmd.wr_add = 1'b1;
                    end
                end
                else if (stat.kind == KIND_REMOVE || stat.kind == KIND_PEEK)
                begin
                    if (stat.empty)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.status = ST_EMPTY;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_pick = 1'b1;
                        state_next  = S_SWAP;
                    end
                end
                else
                begin
                    // unused kind: report the count, change nothing
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SWAP:
            begin
                cmd.emit         = 1'b1;
                cmd.take_element = 1'b1;
                cmd.wr_swap      = (stat.kind == KIND_REMOVE);
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // A slot swap only follows a pick of a non-empty queue
    a_swap_after_pick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_swap |-> $past(cmd.rd_pick))
        else $error("swap write without a preceding slot read");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_accept_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !busy)
        else $error("word taken while busy");

endmodule

FILE: rtl/rqs_dp.sv
module rqs_dp
    import rqs_pkg::*;
#(
    parameter int CAPACITY     = DEF_CAPACITY,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  rqs_in_t   op,
    input  rqs_cmd_t  cmd,
    output rqs_stat_t stat,
    output logic      done,
    output rqs_out_t  result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = RAND_W + CW;

    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [KIND_W-1:0]       kind_reg;
    logic [ELEMENT_BITS-1:0] value_reg;
    logic [AW-1:0]           idx_reg;
    logic [ELEMENT_BITS-1:0] last_reg;
    rqs_out_t                result_reg;
    rqs_out_t                result_next;
    logic                    done_reg;

    logic [PW-1:0]           prod;
    logic [AW-1:0]           last_addr;
    logic [AW-1:0]           raddr;
    logic [AW-1:0]           waddr;
    logic [ELEMENT_BITS-1:0] wdata;
    logic                    we;
    logic [ELEMENT_BITS-1:0] rdata;

    // Slot choice: (random * count) >> 16, always below count
    assign prod      = PW'(op.random_word) * PW'(count_reg);
    assign last_addr = AW'(count_reg - CW'(1));

    // RAM ports
    assign raddr = cmd.rd_pick ? idx_reg : last_addr;
    assign we    = cmd.wr_add | cmd.wr_swap;
    assign waddr = cmd.wr_swap ? idx_reg : AW'(count_reg);
    assign wdata = cmd.wr_swap ? last_reg : value_reg;

    rqs_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Fill count
    always_comb
    begin
        priority if (cmd.wr_add)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.wr_swap)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // Result word
    always_comb
    begin
        result_next.element     = cmd.take_element ? ELEM_W'(rdata) : '0;
        result_next.status      = cmd.status;
        result_next.count_after = COUNT_W'(count_next);
        result_next.is_empty    = (count_next == '0);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.emit;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg  <= op.kind;
            value_reg <= ELEMENT_BITS'(op.value);
            idx_reg   <= prod[RAND_W +: AW];
        end
        if (cmd.hold_last)
        begin
            last_reg <= rdata;
        end
        if (cmd.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign stat.kind  = kind_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(CAPACITY));
    assign done       = done_reg;
    assign result     = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_no_add_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_add |-> !stat.full)
        else $error("append into a full store");

    a_swap_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_swap |-> !stat.empty && idx_reg <= last_addr)
        else $error("swap on empty store or slot beyond last");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> done_reg && result_reg.count_after == COUNT_W'(count_reg))
        else $error("result word missing or count mismatch");

endmodule

FILE: rtl/random_queue_store.sv
// Add, refused and unused operations give their result word from the pick state; remove and
// peek give it from the swap state (last slot read, then chosen slot); the result is registered.
// A new word is taken only while the controller is idle (busy low); the slot RAM has a single read port.
// The receiver cannot stall: done is high for exactly one cycle per accepted word.
// Reset clears the fill count at once; the slot RAM needs no clearing pass.
module random_queue_store
    import rqs_pkg::*;
#(
    parameter int CAPACITY     = DEF_CAPACITY,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  rqs_in_t  op,
    output logic     busy,
    output logic     done,
    output rqs_out_t result
);

    rqs_cmd_t  cmd;
    rqs_stat_t stat;

    rqs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    rqs_dp #(
        .CAPACITY     (CAPACITY),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import rqs_pkg::*;

    // Kind code the block leaves unused
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic     clk;
    logic     rst_n;
    logic     start;
    rqs_in_t  op;
    logic     busy;
    logic     done;
    rqs_out_t result;

    random_queue_store dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // Shadow of the queue contents and the words still owed by the block
    logic [ELEM_W-1:0] shadow_slots [DEF_CAPACITY];
    int unsigned       shadow_fill;
    rqs_out_t          owed_words [$];
    int                failures;
    int                send_gap_pct;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("random_queue_store test failed");
        $finish;
    end

    // Apply one operation to the shadow queue and return the word it should give
    function automatic rqs_out_t queue_outcome(rqs_in_t w);
        rqs_out_t        r;
        longint unsigned pick;
        r = '0;
        r.status = ST_OK;
        case (w.kind)
            KIND_ADD:
                if (shadow_fill >= DEF_CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    shadow_slots[shadow_fill] = w.value;
                    shadow_fill++;
                end
            KIND_REMOVE, KIND_PEEK:
                if (shadow_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    pick = w.random_word;
                    pick = (pick * shadow_fill) >> 16;
                    r.element = shadow_slots[pick];
                    if (w.kind == KIND_REMOVE)
                    begin
                        // swap the last entry into the hole
                        shadow_slots[pick] = shadow_slots[shadow_fill - 1];
                        shadow_fill--;
                    end
                end
            default: ;
        endcase
        r.count_after = COUNT_W'(shadow_fill);
        r.is_empty = (shadow_fill == 0);
        return r;
    endfunction

    function automatic rqs_in_t make_word(logic [KIND_W-1:0] kind, logic [ELEM_W-1:0] value,
                                          logic [RAND_W-1:0] rnd);
        rqs_in_t w;
        w.kind = kind;
        w.value = value;
        w.random_word = rnd;
        return w;
    endfunction

    // Random word with the given mix; the remainder goes to the unused kind
    function automatic rqs_in_t random_word_mix(int add_pct, int take_pct, int peek_pct);
        rqs_in_t w;
        int      roll;
        roll = $urandom_range(0, 99);
        w.value = $urandom;
        w.random_word = RAND_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 15) == 0)
            w.random_word = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if (roll < add_pct)
            w.kind = KIND_ADD;
        else if (roll < add_pct + take_pct)
            w.kind = KIND_REMOVE;
        else if (roll < add_pct + take_pct + peek_pct)
            w.kind = KIND_PEEK;
        else
            w.kind = KIND_UNUSED;
        return w;
    endfunction

    // Drive one word; start stays high afterwards until the next word or a pause
    task automatic send_word(rqs_in_t w);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        op    <= w;
        do
            @(posedge clk);
        while (busy);
        owed_words.insert(owed_words.size(), queue_outcome(w));
    endtask

    // Lower start and hold off until every owed word has come back
    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (owed_words.size() != 0)
            @(posedge clk);
    endtask

    // Result checker: compare each strobed word with the oldest owed one
    always @(posedge clk)
    begin
        rqs_out_t want;
        if (rst_n && done)
        begin
            if (owed_words.size() == 0)
            begin
                $error("result word with none owed: %p", result);
                failures++;
            end
            else
            begin
                want = owed_words.pop_front();
                if (result.element !== want.element)
                begin
                    $error("element: expected %h, got %h", want.element, result.element);
                    failures++;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    failures++;
                end
                if (result.count_after !== want.count_after)
                begin
                    $error("count_after: expected %0d, got %0d",
                           want.count_after, result.count_after);
                    failures++;
                end
                if (result.is_empty !== want.is_empty)
                begin
                    $error("is_empty: expected %b, got %b", want.is_empty, result.is_empty);
                    failures++;
                end
            end
        end
    end

    // Remove and peek on an empty queue, unused kind with nothing stored
    task automatic test_empty_queue();
        send_word(make_word(KIND_REMOVE, $urandom, 16'hFFFF));
        send_word(make_word(KIND_PEEK, $urandom, 16'h0000));
        send_word(make_word(KIND_UNUSED, 32'hFFFF_FFFF, 16'hFFFF));
    endtask

    // Value extremes, then picks at both ends of the random range
    task automatic test_value_and_pick_extremes();
        send_word(make_word(KIND_ADD, 32'h0000_0000, 16'hFFFF));
        send_word(make_word(KIND_ADD, 32'hFFFF_FFFF, 16'h0000));
        send_word(make_word(KIND_ADD, 32'hAAAA_AAAA, 16'h5555));
        send_word(make_word(KIND_ADD, 32'h5555_5555, 16'hAAAA));
        send_word(make_word(KIND_PEEK, 32'h0, 16'h0000));
        send_word(make_word(KIND_PEEK, 32'h0, 16'hFFFF));
        send_word(make_word(KIND_UNUSED, 32'h1234_5678, 16'h8000));
        send_word(make_word(KIND_REMOVE, 32'h0, 16'hFFFF));
        send_word(make_word(KIND_REMOVE, 32'h0, 16'h0000));
        send_word(make_word(KIND_PEEK, 32'h0, 16'h8000));
        // take the rest out so the queue ends empty
        while (shadow_fill != 0)
            send_word(make_word(KIND_REMOVE, $urandom, RAND_W'($urandom_range(0, 65535))));
        send_word(make_word(KIND_PEEK, 32'h0, 16'h4000));
    endtask

    // Random traffic with a given mix of operations
    task automatic test_mixed_traffic(int words, int add_pct, int take_pct, int peek_pct);
        repeat (words)
            send_word(random_word_mix(add_pct, take_pct, peek_pct));
    endtask

    // A burst of words, then the sender waits for every owed word, then a second burst
    task automatic test_pause_for_results();
        test_mixed_traffic(12, 40, 30, 25);
        wait_for_results();
        test_mixed_traffic(12, 40, 30, 25);
    endtask

    // Fill to capacity with random values, then the full-queue cases
    task automatic test_full_queue();
        while (shadow_fill < DEF_CAPACITY)
            send_word(random_word_mix(100, 0, 0));
        send_word(make_word(KIND_ADD, 32'hFFFF_FFFF, 16'hFFFF));
        send_word(make_word(KIND_ADD, 32'h0000_0000, 16'h0000));
        send_word(make_word(KIND_ADD, $urandom, RAND_W'($urandom_range(0, 65535))));
        send_word(make_word(KIND_PEEK, 32'h0, 16'hFFFF));
        send_word(make_word(KIND_PEEK, 32'h0, 16'h0000));
        send_word(make_word(KIND_UNUSED, $urandom, 16'hFFFF));
        // last slot, refill, first slot, refill, then an add into the full queue
        send_word(make_word(KIND_REMOVE, 32'h0, 16'hFFFF));
        send_word(make_word(KIND_ADD, $urandom, 16'h0000));
        send_word(make_word(KIND_REMOVE, 32'h0, 16'h0000));
        send_word(make_word(KIND_ADD, $urandom, 16'h0000));
        send_word(make_word(KIND_ADD, $urandom, 16'h0000));
    endtask

    initial
    begin
        start = 1'b0;
        op = '0;
        rst_n = 1'b0;
        failures = 0;
        shadow_fill = 0;
        send_gap_pct = 6;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender gaps rare
        test_empty_queue();
        test_value_and_pick_extremes();
        test_mixed_traffic(30, 45, 30, 20);
        test_pause_for_results();

        // sender gaps frequent
        send_gap_pct = 63;
        test_full_queue();
        test_mixed_traffic(20, 40, 35, 20);

        // no sender gaps
        send_gap_pct = 0;
        test_mixed_traffic(24, 30, 50, 15);
        test_pause_for_results();

        wait_for_results();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("random_queue_store test passed");
        else
            $display("random_queue_store test failed");
        $finish;
    end

endmodule
